FILE: hdl/dgw_pkg.sv
// ----------------------------------------------------------------------------
// dgw_pkg
// Shared types, constants and the digit font of the decimal glyph writer.
// ----------------------------------------------------------------------------
package dgw_pkg;

    // field widths of the input and result words
    localparam int NUM_W  = 32;
    localparam int COL_W  = 7;
    localparam int PAGE_W = 3;
    localparam int BYTE_W = 8;

    // default digit limit and glyph geometry
    localparam int MAX_DIGITS_DEF = 10;
    localparam int GLYPH_COLUMNS  = 5;

    // display geometry and controller commands
    localparam logic [COL_W:0]     HALF_COLUMNS = 8'd64;
    localparam logic [COL_W:0]     EDGE_COLUMN  = 8'd127;
    localparam logic [PAGE_W-1:0]  LAST_PAGE    = 3'd7;
    localparam logic [BYTE_W-1:0]  PAGE_CMD     = 8'hB8;
    localparam logic [BYTE_W-1:0]  COLUMN_CMD   = 8'h40;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_MOVE,
        S_TEST,
        S_DATA
    } t_state;

    // the three words of a cursor move
    typedef enum logic [1:0] {
        MV_SELECT,
        MV_PAGE,
        MV_COLUMN
    } t_move_step;

    // converter status seen by the sequencer
    typedef struct packed {
        logic done;
        logic ovf;
    } t_conv_stat;

    // one column byte of a 5x7 digit glyph
    function automatic logic [BYTE_W-1:0] font_byte(input logic [3:0] digit,
                                                    input logic [2:0] idx);
        logic [39:0] row;
        logic [BYTE_W-1:0] b;
        unique case (digit)
            4'd0:    row = 40'h3E5149453E;
            4'd1:    row = 40'h00427F4000;
            4'd2:    row = 40'h4261514946;
            4'd3:    row = 40'h2141454B31;
            4'd4:    row = 40'h1814127F10;
            4'd5:    row = 40'h2745454539;
            4'd6:    row = 40'h3C4A494930;
            4'd7:    row = 40'h0171090503;
            4'd8:    row = 40'h3649494936;
            4'd9:    row = 40'h064949291E;
            default: row = '0;
        endcase
        unique case (idx)
            3'd0:    b = row[39:32];
            3'd1:    b = row[31:24];
            3'd2:    b = row[23:16];
            3'd3:    b = row[15:8];
            3'd4:    b = row[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/dgw_if.sv
// ----------------------------------------------------------------------------
// dgw_if
// Valid/ready channels of the decimal glyph writer: number in, bus words out.
// ----------------------------------------------------------------------------
interface dgw_in_if;
    logic                        valid;
    logic                        ready;
    logic [dgw_pkg::NUM_W-1:0]   number;
    logic [dgw_pkg::COL_W-1:0]   start_column;
    logic [dgw_pkg::PAGE_W-1:0]  start_page;

    modport source (output valid, output number, output start_column,
                    output start_page, input ready);
    modport sink   (input valid, input number, input start_column,
                    input start_page, output ready);
endinterface

interface dgw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        is_data;
    logic                        left_select;
    logic                        right_select;
    logic [dgw_pkg::BYTE_W-1:0]  bus_byte;
    logic                        last;

    modport source (output valid, output is_data, output left_select,
                    output right_select, output bus_byte, output last,
                    input ready);
    modport sink   (input valid, input is_data, input left_select,
                    input right_select, input bus_byte, input last,
                    output ready);
endinterface

FILE: hdl/decimal_number_glyph_writer_core.sv
// ----------------------------------------------------------------------------
// decimal_number_glyph_writer_core
// Draws an unsigned number in decimal on a two-controller 128x64 display
// as a stream of chip-select, page, column and font data bus words.
//
//   channel   dir  handshake     payload
//   i_in      in   valid/ready   number, start_column, start_page
//   o_out     out  valid/ready   is_data, left_select, right_select,
//                                bus_byte, last
//
// One number is accepted, converted in the shift-and-add-3 converter, its
// digit count is picked, and the opening cursor move (select, page, column)
// is sent; then per glyph come a cursor test, another cursor move when the
// cursor must move, and the five data words of the glyph.
// The bus words leave through one output register, one word per cycle while the sink takes them.
// A stalled sink holds the sequencer; i_in.ready is high only when idle.
// Reset clears the sequencer and the converter control; no clearing pass.
// ----------------------------------------------------------------------------
module decimal_number_glyph_writer_core #(
    parameter int MAX_DIGITS = dgw_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dgw_in_if.sink     i_in,
    dgw_out_if.source  o_out
);
    import dgw_pkg::*;

    logic                    w_idle;
    logic                    w_start;
    logic [4*MAX_DIGITS-1:0] w_bcd;
    t_conv_stat              w_stat;

    // accept a number only while the sequencer is idle
    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;

    // shift-and-add-3 binary to BCD converter
    dgw_bin2bcd #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_bin2bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_number (i_in.number),
        .o_bcd    (w_bcd),
        .o_stat   (w_stat)
    );

    // cursor and glyph sequencer
    dgw_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_start_column (i_in.start_column),
        .i_start_page   (i_in.start_page),
        .i_bcd          (w_bcd),
        .i_stat         (w_stat),
        .o_idle         (w_idle),
        .o_out          (o_out)
    );

endmodule

FILE: hdl/dgw_bin2bcd.sv
// ----------------------------------------------------------------------------
// dgw_bin2bcd
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
// ----------------------------------------------------------------------------
module dgw_bin2bcd #(
    parameter int MAX_DIGITS = dgw_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dgw_pkg::NUM_W-1:0]   i_number,
    output logic [4*MAX_DIGITS-1:0]     o_bcd,
    output dgw_pkg::t_conv_stat         o_stat
);
    import dgw_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [BCD_W-1:0] w_adj;

    // add 3 to every digit of five or more
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
    end

    // step control: load, shift, finish
    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_ovf  = r_ovf;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_number;
            n_bcd  = '0;
            n_cnt  = '0;
            n_ovf  = 1'b0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bin = {r_bin[NUM_W-2:0], 1'b0};
            n_bcd = {w_adj[BCD_W-2:0], r_bin[NUM_W-1]};
            // a carry out of the top digit means more digits than kept
            n_ovf = r_ovf | w_adj[BCD_W-1];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_ovf <= n_ovf;
    end

    assign o_bcd       = r_bcd;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule

FILE: hdl/dgw_emit.sv
// ----------------------------------------------------------------------------
// dgw_emit
// Cursor and glyph sequencer: walks the digits and drives the bus words.
// ----------------------------------------------------------------------------
module dgw_emit #(
    parameter int MAX_DIGITS = dgw_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dgw_pkg::COL_W-1:0]    i_start_column,
    input  logic [dgw_pkg::PAGE_W-1:0]   i_start_page,
    input  logic [4*MAX_DIGITS-1:0]      i_bcd,
    input  dgw_pkg::t_conv_stat          i_stat,
    output logic                         o_idle,
    dgw_out_if.source                    o_out
);
    import dgw_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [2:0] LAST_J = 3'(GLYPH_COLUMNS - 1);

    typedef struct packed {
        logic              is_data;
        logic              left;
        logic [BYTE_W-1:0] bus_byte;
        logic              last;
    } t_word;

    t_state             r_state, n_state;
    t_move_step         r_mv, n_mv;
    logic [COL_W:0]     r_col, n_col;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic               r_left, n_left;
    logic [IDX_W-1:0]   r_g, n_g;
    logic [2:0]         r_j, n_j;
    logic               r_to_data, n_to_data;
    logic               r_out_valid, n_out_valid;
    t_word              r_word, n_word;

    logic               w_load_ok;
    logic               w_load;
    logic [COL_W:0]     w_reach;
    logic               w_wrap;
    logic               w_right;
    logic               w_move;
    logic [IDX_W-1:0]   w_top;
    logic [3:0]         w_digit;

    // output register takes a word when empty or being drained
    assign w_load_ok = !r_out_valid || o_out.ready;
    assign w_load    = w_load_ok && (r_state == S_MOVE || r_state == S_DATA);

    // cursor test before each glyph
    assign w_reach = r_col + (COL_W + 1)'(GLYPH_COLUMNS + 1);
    assign w_wrap  = (w_reach >= EDGE_COLUMN);
    assign w_right = (r_col < HALF_COLUMNS) && (w_reach >= HALF_COLUMNS);
    assign w_move  = w_wrap ? (r_page != LAST_PAGE) : w_right;

    // index of the top nonzero digit
    always_comb begin
        w_top = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i_bcd[4*i +: 4] != 4'd0) begin
                w_top = IDX_W'(i);
            end
        end
    end

    assign w_digit = i_bcd[4*r_g +: 4];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_CONV;
            S_CONV: if (i_stat.done) n_state = S_MOVE;
            S_MOVE: begin
                if (w_load && r_mv == MV_COLUMN) begin
                    n_state = r_to_data ? S_DATA : S_TEST;
                end
            end
            S_TEST: n_state = w_move ? S_MOVE : S_DATA;
            S_DATA: begin
                if (w_load && r_j == LAST_J) begin
                    n_state = (r_g == '0) ? S_IDLE : S_TEST;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cursor, digit walk and bus words
    always_comb begin
        n_mv        = r_mv;
        n_col       = r_col;
        n_page      = r_page;
        n_left      = r_left;
        n_g         = r_g;
        n_j         = r_j;
        n_to_data   = r_to_data;
        n_word      = r_word;
        n_out_valid = o_out.ready ? 1'b0 : r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_col  = {1'b0, i_start_column};
                    n_page = i_start_page;
                end
            end
            S_CONV: begin
                if (i_stat.done) begin
                    n_g       = i_stat.ovf ? IDX_W'(MAX_DIGITS - 1) : w_top;
                    n_left    = (r_col < HALF_COLUMNS);
                    n_mv      = MV_SELECT;
                    n_to_data = 1'b0;
                end
            end
            S_MOVE: begin
                if (w_load) begin
                    n_out_valid     = 1'b1;
                    n_word.is_data  = 1'b0;
                    n_word.left     = r_left;
                    n_word.last     = 1'b0;
                    unique case (r_mv)
                        MV_SELECT: begin
                            n_word.bus_byte = '0;
                            n_mv            = MV_PAGE;
                        end
                        MV_PAGE: begin
                            n_word.bus_byte = PAGE_CMD | {{(BYTE_W - PAGE_W){1'b0}}, r_page};
                            n_mv            = MV_COLUMN;
                        end
                        MV_COLUMN: begin
                            n_word.bus_byte = COLUMN_CMD | {2'b00, r_col[5:0]};
                            n_mv            = MV_SELECT;
                        end
                        default: begin
                            n_word.bus_byte = '0;
                            n_mv            = MV_SELECT;
                        end
                    endcase
                end
            end
            S_TEST: begin
                n_j = '0;
                if (w_move) begin
                    n_mv      = MV_SELECT;
                    n_to_data = 1'b1;
                    if (w_wrap) begin
                        n_page = r_page + 1'b1;
                        n_col  = '0;
                        n_left = 1'b1;
                    end else begin
                        n_col  = HALF_COLUMNS;
                        n_left = 1'b0;
                    end
                end
            end
            S_DATA: begin
                if (w_load) begin
                    n_out_valid     = 1'b1;
                    n_word.is_data  = 1'b1;
                    n_word.left     = r_left;
                    n_word.bus_byte = font_byte(w_digit, r_j);
                    n_word.last     = (r_j == LAST_J) && (r_g == '0);
                    if (r_j == LAST_J) begin
                        n_j   = '0;
                        n_col = r_col + (COL_W + 1)'(GLYPH_COLUMNS);
                        if (r_g != '0) begin
                            n_g = r_g - 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mv      <= n_mv;
        r_col     <= n_col;
        r_page    <= n_page;
        r_left    <= n_left;
        r_g       <= n_g;
        r_j       <= n_j;
        r_to_data <= n_to_data;
        r_word    <= n_word;
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.is_data      = r_word.is_data;
    assign o_out.left_select  = r_word.left;
    assign o_out.right_select = !r_word.left;
    assign o_out.bus_byte     = r_word.bus_byte;
    assign o_out.last         = r_word.last;

    // last glyph column closes the number
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA && w_load && r_j == LAST_J && r_g == '0)
        |=> (r_state == S_IDLE && o_out.last))
        else $error("final data word did not end the sequence");

    // exactly one controller selected on every word
    a_one_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.left_select != o_out.right_select))
        else $error("chip selects not complementary");

    // conversion finishes only while the sequencer waits for it
    a_done_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> (r_state == S_CONV))
        else $error("conversion done outside of conversion wait");

    // a glyph column index never passes the glyph width
    a_col_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_j <= LAST_J))
        else $error("glyph column index out of range");

endmodule
